/* src/tpcc_pkg.sv */
package tpcc_pkg;

    // Keyword table geometry
    localparam int NUM_KW  = 7;
    localparam int KW_SPAN = 7;

    // Header limits and field codes
    localparam logic [5:0] IP_MIN_HDR  = 6'd20;
    localparam logic [5:0] TCP_MIN_HDR = 6'd20;
    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [4:0] LINK_HDR_RESET = 5'd14;

    // Byte offsets from the start of the IP header (TCP data offset: from the TCP header)
    localparam logic [15:0] OFS_TOTAL_HI = 16'd2;
    localparam logic [15:0] OFS_TOTAL_LO = 16'd3;
    localparam logic [15:0] OFS_PROTO    = 16'd9;
    localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
    localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
    localparam logic [15:0] OFS_TCP_DOFF  = 16'd12;

    localparam logic [2:0] KW_NONE = 3'd7;

    // Keywords, first character in the lowest byte
    localparam logic [KW_SPAN*8-1:0] KW_TEXT [NUM_KW] = '{
        {32'h0, "dda"},
        {32'h0, "tes"},
        "ecalper",
        {8'h0, "dneppa"},
        "dneperp",
        {32'h0, "sac"},
        {8'h0, "eteled"}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd3, 3'd7, 3'd6, 3'd7, 3'd3, 3'd6
    };

    typedef enum logic [2:0] {
        VERDICT_REPLICATE  = 3'd0,
        VERDICT_NOT_TCP    = 3'd1,
        VERDICT_SHORT_TCP  = 3'd2,
        VERDICT_NO_PAYLOAD = 3'd3,
        VERDICT_NO_KEYWORD = 3'd4,
        VERDICT_TRUNCATED  = 3'd5
    } verdict_t;

    // Per-frame parse state
    typedef struct packed {
        logic [5:0]        ip_hdr_len;
        logic [5:0]        tcp_hdr_len;
        logic [15:0]       ip_total_len;
        logic              proto_tcp;
        logic [31:0]       src_addr;
        logic [NUM_KW-1:0] kw_alive;
    } frame_state_t;

    localparam frame_state_t FRAME_RESET = '{
        ip_hdr_len:   6'd0,
        tcp_hdr_len:  6'd0,
        ip_total_len: 16'd0,
        proto_tcp:    1'b0,
        src_addr:     32'd0,
        kw_alive:     {NUM_KW{1'b1}}
    };

    // One byte handed to the parser
    typedef struct packed {
        logic       step;
        logic [7:0] data;
        logic       last;
    } byte_in_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [2:0]  keyword_index;
        logic [7:0]  payload_offset;
        logic [15:0] payload_length;
        logic [31:0] source_address;
    } result_t;

endpackage

/* src/tpcc_parser.sv */
module tpcc_parser
    import tpcc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  byte_in_t     byte_in,
    input  logic [4:0]   link_hdr,
    output frame_state_t upd,
    output logic [15:0]  captured
);

    localparam logic [15:0] MAX_POS = 16'(MAX_FRAME_BYTES);

    logic [15:0]  pos_reg;
    logic [15:0]  pos_next;
    frame_state_t st_reg;
    frame_state_t st_next;

    logic [15:0] p;
    logic [15:0] l16;
    logic [15:0] tpos;
    logic [15:0] start;
    logic [15:0] kw_ofs;
    logic [2:0]  kw_pos;
    logic [7:0]  lc_byte;
    logic [16:0] p_inc;
    logic        in_snap;

    assign p       = pos_reg;
    assign l16     = {11'd0, link_hdr};
    assign tpos    = l16 + {10'd0, st_reg.ip_hdr_len} + OFS_TCP_DOFF;
    assign start   = l16 + {10'd0, st_reg.ip_hdr_len} + {10'd0, st_reg.tcp_hdr_len};
    assign kw_ofs  = p - start;
    assign kw_pos  = kw_ofs[2:0];
    assign in_snap = p < MAX_POS;
    assign p_inc   = {1'b0, p} + 17'd1;
    assign captured = (p_inc < {1'b0, MAX_POS}) ? p_inc[15:0] : MAX_POS;

    // fold case for keyword compare
    assign lc_byte = (byte_in.data >= 8'h41 && byte_in.data <= 8'h5A) ?
                     byte_in.data + 8'h20 : byte_in.data;

    // state after this byte
    always_comb begin
        upd = st_reg;
        if (in_snap) begin
            if (p == l16) begin
                upd.ip_hdr_len = {byte_in.data[3:0], 2'b00};
            end else if (p == l16 + OFS_TOTAL_HI) begin
                upd.ip_total_len[15:8] = byte_in.data;
            end else if (p == l16 + OFS_TOTAL_LO) begin
                upd.ip_total_len[7:0] = byte_in.data;
            end else if (p == l16 + OFS_PROTO) begin
                upd.proto_tcp = (byte_in.data == PROTO_TCP);
            end else if (p >= l16 + OFS_SRC_FIRST && p <= l16 + OFS_SRC_LAST) begin
                upd.src_addr = {st_reg.src_addr[23:0], byte_in.data};
            end

            if (p > l16 && st_reg.ip_hdr_len >= IP_MIN_HDR) begin
                if (p == tpos) begin
                    upd.tcp_hdr_len = {byte_in.data[7:4], 2'b00};
                end
                if (p > tpos && st_reg.tcp_hdr_len >= TCP_MIN_HDR &&
                    p >= start && kw_ofs < 16'(KW_SPAN)) begin
                    for (int k = 0; k < NUM_KW; k++) begin
                        if (kw_pos < KW_LEN[k] &&
                            KW_TEXT[k][{kw_pos, 3'b000} +: 8] != lc_byte) begin
                            upd.kw_alive[k] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // register update, cleared after the frame's last byte
    always_comb begin
        pos_next = pos_reg;
        st_next  = st_reg;
        if (byte_in.step) begin
            if (byte_in.last) begin
                pos_next = 16'd0;
                st_next  = FRAME_RESET;
            end else begin
                st_next = upd;
                if (pos_reg != 16'hFFFF) begin
                    pos_next = pos_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 16'd0;
            st_reg  <= FRAME_RESET;
        end else begin
            pos_reg <= pos_next;
            st_reg  <= st_next;
        end
    end

    // frame state returns to its start after a verdict
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_in.step && byte_in.last) |=> (pos_reg == 16'd0 && st_reg == FRAME_RESET))
        else $error("frame state not cleared after last byte");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_in.step && !byte_in.last && pos_reg != 16'hFFFF)
        |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("byte position did not advance");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !byte_in.step |=> ($stable(pos_reg) && $stable(st_reg)))
        else $error("parse state moved without a byte");

endmodule

/* src/tpcc_verdict.sv */
module tpcc_verdict
    import tpcc_pkg::*;
(
    input  frame_state_t st,
    input  logic [15:0]  captured,
    input  logic [4:0]   link_hdr,
    output result_t      res
);

    logic [15:0] l16;
    logic [15:0] proto_lim;
    logic [15:0] tcp_lim;
    logic [6:0]  hdrs;
    logic [15:0] start;
    logic [15:0] plen;
    logic        found;
    logic [2:0]  sel;

    assign l16       = {11'd0, link_hdr};
    assign proto_lim = l16 + OFS_PROTO;
    assign tcp_lim   = l16 + {10'd0, st.ip_hdr_len} + OFS_TCP_DOFF;
    assign hdrs      = {1'b0, st.ip_hdr_len} + {1'b0, st.tcp_hdr_len};
    assign start     = l16 + {9'd0, hdrs};
    assign plen      = st.ip_total_len - {9'd0, hdrs};

    // first live keyword that fits the payload
    always_comb begin
        found = 1'b0;
        sel   = KW_NONE;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!found && {13'd0, KW_LEN[k]} <= plen && st.kw_alive[k]) begin
                found = 1'b1;
                sel   = 3'(k);
            end
        end
    end

    // verdict priority chain
    always_comb begin
        res.verdict        = VERDICT_NO_KEYWORD;
        res.keyword_index  = KW_NONE;
        res.payload_offset = 8'd0;
        res.payload_length = 16'd0;
        res.source_address = st.src_addr;
        if (captured <= proto_lim) begin
            res.verdict = VERDICT_TRUNCATED;
        end else if (st.ip_hdr_len < IP_MIN_HDR || !st.proto_tcp) begin
            res.verdict = VERDICT_NOT_TCP;
        end else if (captured <= tcp_lim) begin
            res.verdict = VERDICT_TRUNCATED;
        end else if (st.tcp_hdr_len < TCP_MIN_HDR) begin
            res.verdict = VERDICT_SHORT_TCP;
        end else begin
            res.payload_offset = start[7:0];
            if (st.ip_total_len < {9'd0, hdrs}) begin
                res.verdict = VERDICT_TRUNCATED;
            end else begin
                res.payload_length = plen;
                if (plen == 16'd0) begin
                    res.verdict = VERDICT_NO_PAYLOAD;
                end else if (found) begin
                    if (captured >= start + {13'd0, KW_LEN[sel]}) begin
                        res.verdict       = VERDICT_REPLICATE;
                        res.keyword_index = sel;
                    end else begin
                        res.verdict = VERDICT_TRUNCATED;
                    end
                end
            end
        end
    end

endmodule

/* src/tcp_payload_command_classifier.sv */
// TCP payload command classifier.
// s_ channel: one captured frame byte per transaction in s_tdata, s_tlast on
// the frame's last byte. m_ channel: one verdict per frame, produced only for
// the transaction that carried s_tlast.
// cfg_ channel: writes link_header_bytes (reset 14); write only while idle.
// Each accepted byte goes into an input register and is parsed from there
// against the per-frame header state; the verdict of a last byte lands in
// the output register, which drives m_tvalid. One byte per cycle is
// sustained while no last byte waits for the output slot; the per-frame
// state update is combinational compares and small adds.
// When the receiver stalls with a verdict waiting, non-last bytes still flow;
// a last byte holds in the input register until the output slot frees, and
// s_tready drops only then.
// Reset clears the frame position, header state and both valid flags and
// sets link_header_bytes to 14.
// Bytes at or beyond MAX_FRAME_BYTES within a frame are counted but not
// parsed.
module tcp_payload_command_classifier
    import tpcc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] verdict, [5:3] keyword_index, [13:6] payload_offset,
    // [29:14] payload_length, [61:30] source_address, [63:62] zero
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // link_header_bytes
);

    logic [4:0]   link_hdr_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;

    logic         out_free;
    logic         fire;
    logic         s_take;
    byte_in_t     byte_in;
    frame_state_t upd;
    logic [15:0]  captured;
    result_t      res;

    // handshake control
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || fire;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign byte_in.step = fire;
    assign byte_in.data = in_byte_reg;
    assign byte_in.last = in_last_reg;

    tpcc_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_in  (byte_in),
        .link_hdr (link_hdr_reg),
        .upd      (upd),
        .captured (captured)
    );

    tpcc_verdict u_verdict (
        .st       (upd),
        .captured (captured),
        .link_hdr (link_hdr_reg),
        .res      (res)
    );

    // valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_hdr_reg  <= LINK_HDR_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                link_hdr_reg <= cfg_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire && in_last_reg) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.source_address, out_reg.payload_length,
                       out_reg.payload_offset, out_reg.keyword_index, out_reg.verdict};

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire && in_last_reg))
        else $error("result appeared without a last byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(fire && in_last_reg))
        else $error("pending result overwritten");

    a_kw_only_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.verdict != VERDICT_REPLICATE)
        |-> out_reg.keyword_index == KW_NONE)
        else $error("keyword index set without a match");

endmodule
